// ===== rtl/core/gregorian_date_advance_unit_macros.svh =====
// assertion macros shared by the date advance unit
`ifndef GREGORIAN_DATE_ADVANCE_UNIT_MACROS_SVH
`define GREGORIAN_DATE_ADVANCE_UNIT_MACROS_SVH

// condition holds on every clock edge out of reset
`define GDA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("gda assertion failed");

// antecedent implies consequent in the same cycle
`define GDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gda assertion failed");

`endif

// ===== rtl/core/gda_pkg.sv =====
package gda_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int WD_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_FIELD_W = 16;
	localparam int CENT_W = 7;
	localparam int QCENT_W = 8;
	localparam int HSUM_W = 15;
	localparam int QPROD_W = 27;
	localparam int WPROD_W = 31;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_ADD = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0] DAY_LAST_DEC = 5'd31;

	localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
	localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd2001;
	localparam logic [CENT_W-1:0] RESET_YEAR_LO = 7'd1;
	localparam logic [CENT_W-1:0] RESET_YEAR_HI = 7'd20;
	localparam logic [CENT_W-1:0] CENT_LAST = 7'd99;
	localparam logic [YEAR_W-1:0] YEARS_PER_CENT = 14'd100;

	// reciprocal multipliers: y / 100 for y < 16384, h / 7 for h < 20000
	localparam logic [12:0] Q100_MUL = 13'd5243;
	localparam int Q100_SHIFT = 19;
	localparam logic [15:0] Q7_MUL = 16'd37450;
	localparam int Q7_SHIFT = 18;
	localparam logic [HSUM_W-1:0] DAYS_PER_WEEK = 15'd7;
	localparam logic [HSUM_W-1:0] ZELLER_SUNDAY_OFFSET = 15'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADD,
		ST_ZEL1,
		ST_ZEL2,
		ST_ZEL3
	} gda_state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic step;
		logic zel1;
		logic zel2;
		logic emit;
	} gda_cmd_t;

	typedef struct packed {
		logic op_add;
		logic step_done;
		logic out_free;
	} gda_stat_t;

	function automatic logic is_leap(input logic [CENT_W-1:0] lo, input logic [CENT_W-1:0] hi);
		return (lo != '0) ? (lo[1:0] == 2'b00) : (hi[1:0] == 2'b00);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// (13 * (m + 1)) / 5 with january and february as months 13 and 14
	function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] m);
		logic [5:0] t;
		unique case (m)
			4'd1: t = 6'd36;
			4'd2: t = 6'd39;
			4'd3: t = 6'd10;
			4'd4: t = 6'd13;
			4'd5: t = 6'd15;
			4'd6: t = 6'd18;
			4'd7: t = 6'd20;
			4'd8: t = 6'd23;
			4'd9: t = 6'd26;
			4'd10: t = 6'd28;
			4'd11: t = 6'd31;
			4'd12: t = 6'd33;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/gda_req_if.sv =====
interface gda_req_if;
	logic valid;
	logic ready;
	logic operation;
	logic [gda_pkg::YEAR_W-1:0] set_year;
	logic [gda_pkg::MONTH_W-1:0] set_month;
	logic [gda_pkg::DAY_W-1:0] set_day;
	logic [gda_pkg::COUNT_FIELD_W-1:0] day_count;

	modport source (output valid, operation, set_year, set_month, set_day, day_count,
		input ready);
	modport sink (input valid, operation, set_year, set_month, set_day, day_count,
		output ready);
endinterface

// ===== rtl/core/gda_rsp_if.sv =====
interface gda_rsp_if;
	logic valid;
	logic ready;
	logic [gda_pkg::YEAR_W-1:0] cur_year;
	logic [gda_pkg::MONTH_W-1:0] cur_month;
	logic [gda_pkg::DAY_W-1:0] cur_day;
	logic [gda_pkg::WD_W-1:0] weekday;
	logic [gda_pkg::STATUS_W-1:0] status;

	modport source (output valid, cur_year, cur_month, cur_day, weekday, status,
		input ready);
	modport sink (input valid, cur_year, cur_month, cur_day, weekday, status,
		output ready);
endinterface

// ===== rtl/core/gda_ctrl.sv =====
module gda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gda_pkg::gda_stat_t  stat,
	output gda_pkg::gda_cmd_t   cmd
);

	gda_pkg::gda_state_t state_q;
	gda_pkg::gda_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = stat.op_add ? gda_pkg::ST_ADD : gda_pkg::ST_CHECK;
				end
			end
			gda_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = gda_pkg::ST_ZEL1;
			end
			gda_pkg::ST_ADD: begin
				cmd.step = 1'b1;
				if (stat.step_done) begin
					state_d = gda_pkg::ST_ZEL1;
				end
			end
			gda_pkg::ST_ZEL1: begin
				cmd.zel1 = 1'b1;
				state_d = gda_pkg::ST_ZEL2;
			end
			gda_pkg::ST_ZEL2: begin
				cmd.zel2 = 1'b1;
				state_d = gda_pkg::ST_ZEL3;
			end
			gda_pkg::ST_ZEL3: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = gda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/gda_datapath.sv =====
`include "gregorian_date_advance_unit_macros.svh"

module gda_datapath #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gda_pkg::gda_cmd_t                   cmd,
	output gda_pkg::gda_stat_t                  stat,
	input  logic                                operation,
	input  logic [gda_pkg::YEAR_W-1:0]          set_year,
	input  logic [gda_pkg::MONTH_W-1:0]         set_month,
	input  logic [gda_pkg::DAY_W-1:0]           set_day,
	input  logic [gda_pkg::COUNT_FIELD_W-1:0]   day_count,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [gda_pkg::YEAR_W-1:0]          cur_year,
	output logic [gda_pkg::MONTH_W-1:0]         cur_month,
	output logic [gda_pkg::DAY_W-1:0]           cur_day,
	output logic [gda_pkg::WD_W-1:0]            weekday,
	output logic [gda_pkg::STATUS_W-1:0]        status
);

	localparam int CW = (COUNT_WIDTH > gda_pkg::COUNT_FIELD_W) ?
		gda_pkg::COUNT_FIELD_W : COUNT_WIDTH;
	localparam int XW = CW + 6;

	// stored date, year also kept split into centuries and year of century
	logic [gda_pkg::YEAR_W-1:0] year_q;
	logic [gda_pkg::MONTH_W-1:0] month_q;
	logic [gda_pkg::DAY_W-1:0] day_q;
	logic [gda_pkg::CENT_W-1:0] lo_q;
	logic [gda_pkg::CENT_W-1:0] hi_q;

	logic [CW-1:0] rem_q;
	logic [gda_pkg::YEAR_W-1:0] sy_q;
	logic [gda_pkg::MONTH_W-1:0] sm_q;
	logic [gda_pkg::DAY_W-1:0] sd_q;
	logic [gda_pkg::QCENT_W-1:0] q100_q;
	logic [gda_pkg::STATUS_W-1:0] status_q;
	logic [gda_pkg::HSUM_W-1:0] h_q;
	logic [gda_pkg::WPROD_W-1:0] prod_q;

	logic out_valid_q;
	logic [gda_pkg::YEAR_W-1:0] out_year_q;
	logic [gda_pkg::MONTH_W-1:0] out_month_q;
	logic [gda_pkg::DAY_W-1:0] out_day_q;
	logic [gda_pkg::WD_W-1:0] out_wd_q;
	logic [gda_pkg::STATUS_W-1:0] out_status_q;

	// add step
	logic leap_cur;
	logic [gda_pkg::DAY_W-1:0] mlen_cur;
	logic [gda_pkg::DAY_W-1:0] left;
	logic [XW-1:0] rem_x;
	logic fits;
	logic at_dec;
	logic at_max;

	assign leap_cur = gda_pkg::is_leap(lo_q, hi_q);
	assign mlen_cur = gda_pkg::month_len(month_q, leap_cur);
	assign left = mlen_cur - day_q;
	assign rem_x = XW'(rem_q);
	assign fits = rem_x <= XW'(left);
	assign at_dec = month_q >= gda_pkg::MONTH_DEC;
	assign at_max = year_q >= gda_pkg::MAX_YEAR;

	// set check
	logic [gda_pkg::QPROD_W-1:0] q_prod;
	logic [gda_pkg::CENT_W-1:0] y_rem;
	logic s_leap;
	logic s_ok;

	assign q_prod = gda_pkg::QPROD_W'(set_year) * gda_pkg::QPROD_W'(gda_pkg::Q100_MUL);
	assign y_rem = gda_pkg::CENT_W'(sy_q -
		gda_pkg::YEAR_W'(q100_q) * gda_pkg::YEARS_PER_CENT);
	assign s_leap = (y_rem != '0) ? (sy_q[1:0] == 2'b00) : (q100_q[1:0] == 2'b00);
	assign s_ok = (sy_q != '0) && (sy_q <= gda_pkg::MAX_YEAR) &&
		(sm_q >= gda_pkg::MONTH_JAN) && (sm_q <= gda_pkg::MONTH_DEC) &&
		(sd_q != '0) && (sd_q <= gda_pkg::month_len(sm_q, s_leap));

	// zeller
	logic early;
	logic [gda_pkg::YEAR_W-1:0] zy;
	logic [gda_pkg::CENT_W-1:0] zc;
	logic [gda_pkg::HSUM_W-1:0] h_sum;
	logic [gda_pkg::HSUM_W-1:0] q7;
	logic [gda_pkg::WD_W-1:0] wd;

	assign early = month_q <= gda_pkg::MONTH_FEB;
	assign zy = early ? year_q - 14'd1 : year_q;
	assign zc = (early && lo_q == '0) ? hi_q - 7'd1 : hi_q;
	assign h_sum = gda_pkg::HSUM_W'(day_q) + gda_pkg::HSUM_W'(gda_pkg::zeller_term(month_q)) +
		gda_pkg::HSUM_W'(zy) + gda_pkg::HSUM_W'(zy >> 2) + gda_pkg::HSUM_W'(zc >> 2) -
		gda_pkg::HSUM_W'(zc) + gda_pkg::ZELLER_SUNDAY_OFFSET;
	assign q7 = gda_pkg::HSUM_W'(prod_q >> gda_pkg::Q7_SHIFT);
	assign wd = gda_pkg::WD_W'(h_q - q7 * gda_pkg::DAYS_PER_WEEK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= gda_pkg::RESET_YEAR;
			month_q <= gda_pkg::MONTH_JAN;
			day_q <= gda_pkg::DAY_FIRST;
			lo_q <= gda_pkg::RESET_YEAR_LO;
			hi_q <= gda_pkg::RESET_YEAR_HI;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.check && s_ok) begin
				year_q <= sy_q;
				month_q <= sm_q;
				day_q <= sd_q;
				lo_q <= y_rem;
				hi_q <= gda_pkg::CENT_W'(q100_q);
			end else if (cmd.step && !fits) begin
				if (at_dec && at_max) begin
					year_q <= gda_pkg::MAX_YEAR;
					month_q <= gda_pkg::MONTH_DEC;
					day_q <= gda_pkg::DAY_LAST_DEC;
					lo_q <= gda_pkg::CENT_LAST;
					hi_q <= gda_pkg::CENT_LAST;
				end else if (at_dec) begin
					year_q <= year_q + 14'd1;
					month_q <= gda_pkg::MONTH_JAN;
					day_q <= gda_pkg::DAY_FIRST;
					if (lo_q == gda_pkg::CENT_LAST) begin
						lo_q <= '0;
						hi_q <= hi_q + 7'd1;
					end else begin
						lo_q <= lo_q + 7'd1;
					end
				end else begin
					month_q <= month_q + 4'd1;
					day_q <= gda_pkg::DAY_FIRST;
				end
			end else if (cmd.step) begin
				day_q <= day_q + gda_pkg::DAY_W'(rem_x);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sy_q <= set_year;
			sm_q <= set_month;
			sd_q <= set_day;
			rem_q <= day_count[CW-1:0];
			q100_q <= q_prod[gda_pkg::QPROD_W-1:gda_pkg::Q100_SHIFT];
			status_q <= gda_pkg::STATUS_OK;
		end
		if (cmd.check && !s_ok) begin
			status_q <= gda_pkg::STATUS_INVALID;
		end
		if (cmd.step && !fits) begin
			rem_q <= CW'(rem_x - XW'(left) - XW'(1));
			if (at_dec && at_max) begin
				status_q <= gda_pkg::STATUS_OVERFLOW;
			end
		end
		if (cmd.zel1) begin
			h_q <= h_sum;
		end
		if (cmd.zel2) begin
			prod_q <= gda_pkg::WPROD_W'(h_q) * gda_pkg::WPROD_W'(gda_pkg::Q7_MUL);
		end
		if (cmd.emit) begin
			out_year_q <= year_q;
			out_month_q <= month_q;
			out_day_q <= day_q;
			out_wd_q <= wd;
			out_status_q <= status_q;
		end
	end

	assign stat.op_add = operation == gda_pkg::OP_ADD;
	assign stat.step_done = fits || (at_dec && at_max);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign cur_year = out_year_q;
	assign cur_month = out_month_q;
	assign cur_day = out_day_q;
	assign weekday = out_wd_q;
	assign status = out_status_q;

	`GDA_ASSERT_ALWAYS(a_day_in_month, clk, arst_n, day_q != '0 && day_q <= mlen_cur)
	`GDA_ASSERT_ALWAYS(a_year_split, clk, arst_n, year_q == gda_pkg::YEAR_W'(hi_q) * gda_pkg::YEARS_PER_CENT + gda_pkg::YEAR_W'(lo_q))
	`GDA_ASSERT_IMPLY(a_weekday_range, clk, arst_n, out_valid_q, out_wd_q <= 3'd6)
	`GDA_ASSERT_IMPLY(a_overflow_date, clk, arst_n, cmd.emit && status_q == gda_pkg::STATUS_OVERFLOW, year_q == gda_pkg::MAX_YEAR && month_q == gda_pkg::MONTH_DEC && day_q == gda_pkg::DAY_LAST_DEC)

endmodule

// ===== rtl/core/gregorian_date_advance_unit.sv =====
// sequence: a set item goes through the check state and then zel1, zel2 and zel3, an add
// item through the add state, which moves on month by month until the rest of the count
// fits in the month or the top date is reached, and then through zel1, zel2 and zel3
// throughput: one item at a time, the last state waits while the result register is still
// full and writes the result into it once it is free
// reset: date is 2001-01-01, no result pending
module gregorian_date_advance_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	gda_req_if.sink     req,
	gda_rsp_if.source   rsp
);

	gda_pkg::gda_cmd_t cmd;
	gda_pkg::gda_stat_t stat;

	gda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gda_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (req.operation),
		.set_year  (req.set_year),
		.set_month (req.set_month),
		.set_day   (req.set_day),
		.day_count (req.day_count),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cur_year  (rsp.cur_year),
		.cur_month (rsp.cur_month),
		.cur_day   (rsp.cur_day),
		.weekday   (rsp.weekday),
		.status    (rsp.status)
	);

endmodule

// ===== tb/tb_gregorian_date_advance_unit.sv =====
module tb_gregorian_date_advance_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned RANDOM_ITEMS = 75;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam logic [gda_pkg::WD_W-1:0] WD_MONDAY = 3'd1;
	localparam int NDIR = 25;

	typedef struct packed {
		logic [gda_pkg::YEAR_W-1:0] yr;
		logic [gda_pkg::MONTH_W-1:0] mo;
		logic [gda_pkg::DAY_W-1:0] dy;
		logic [gda_pkg::WD_W-1:0] wd;
		logic [gda_pkg::STATUS_W-1:0] st;
	} date_rsp_t;

	typedef struct packed {
		logic op;
		logic [gda_pkg::YEAR_W-1:0] yr;
		logic [gda_pkg::MONTH_W-1:0] mo;
		logic [gda_pkg::DAY_W-1:0] dy;
		logic [gda_pkg::COUNT_FIELD_W-1:0] cnt;
		logic typed;
		date_rsp_t want;
	} date_req_t;

	localparam date_rsp_t START_OK = '{gda_pkg::RESET_YEAR, gda_pkg::MONTH_JAN,
		gda_pkg::DAY_FIRST, WD_MONDAY, gda_pkg::STATUS_OK};
	localparam date_rsp_t START_BAD = '{gda_pkg::RESET_YEAR, gda_pkg::MONTH_JAN,
		gda_pkg::DAY_FIRST, WD_MONDAY, gda_pkg::STATUS_INVALID};

	logic clk = 1'b0;
	logic arst_n;
	logic calm;
	date_req_t req_row;

	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;

	int unsigned cal_year = 2001;
	int unsigned cal_month = 1;
	int unsigned cal_day = 1;
	date_rsp_t date_q[$];

	// rows while the date is still 2001-01-01 carry their answer
	date_req_t dir_rows [NDIR] = '{
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd0, 1'b1, START_OK},
		'{gda_pkg::OP_SET, 14'd0, gda_pkg::MONTH_JAN, 5'd1, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd16383, gda_pkg::MONTH_DEC, 5'd31, 16'hFFFF, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd10000, gda_pkg::MONTH_JAN, 5'd1, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2000, 4'd0, 5'd1, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2000, 4'd15, 5'd1, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2000, 4'd13, 5'd1, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2000, gda_pkg::MONTH_FEB, 5'd0, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd1900, gda_pkg::MONTH_FEB, 5'd29, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2100, gda_pkg::MONTH_FEB, 5'd29, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2000, gda_pkg::MONTH_APR, 5'd31, 16'd0, 1'b1, START_BAD},
		'{gda_pkg::OP_SET, 14'd2000, gda_pkg::MONTH_FEB, 5'd29, 16'd0, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd1, 1'b0, '0},
		'{gda_pkg::OP_SET, 14'd1, gda_pkg::MONTH_JAN, 5'd1, 16'd0, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd365, 1'b0, '0},
		'{gda_pkg::OP_SET, 14'd9999, gda_pkg::MONTH_DEC, 5'd31, 16'd0, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd1, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'hFFFF, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd0, 1'b0, '0},
		'{gda_pkg::OP_SET, 14'd9999, gda_pkg::MONTH_JAN, 5'd1, 16'hFFFF, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'h3FFF, 4'hF, 5'h1F, 16'd364, 1'b0, '0},
		'{gda_pkg::OP_SET, 14'd2024, gda_pkg::MONTH_JAN, 5'd31, 16'd0, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'd29, 1'b0, '0},
		'{gda_pkg::OP_SET, 14'd1999, gda_pkg::MONTH_DEC, 5'd31, 16'd0, 1'b0, '0},
		'{gda_pkg::OP_ADD, 14'd0, 4'd0, 5'd0, 16'hFFFF, 1'b0, '0}
	};

	gda_req_if req_ch ();
	gda_rsp_if rsp_ch ();

	assign req_ch.operation = req_row.op;
	assign req_ch.set_year = req_row.yr;
	assign req_ch.set_month = req_row.mo;
	assign req_ch.set_day = req_row.dy;
	assign req_ch.day_count = req_row.cnt;

	gregorian_date_advance_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5ns clk = ~clk;

	function automatic bit leap_year(int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		if (m == gda_pkg::MONTH_FEB) begin
			return leap_year(y) ? 29 : 28;
		end
		if (m == gda_pkg::MONTH_APR || m == gda_pkg::MONTH_JUN ||
				m == gda_pkg::MONTH_SEP || m == gda_pkg::MONTH_NOV) begin
			return 30;
		end
		return 31;
	endfunction

	// zeller's congruence, shifted so that sunday is zero
	function automatic int unsigned weekday_of(int unsigned y, int unsigned m, int unsigned d);
		int unsigned h;
		if (m <= 2) begin
			m += 12;
			y -= 1;
		end
		h = d + (13 * (m + 1)) / 5 + y + y / 4 + y / 400;
		h = (h + 7000 - y / 100) % 7;
		return (h + 6) % 7;
	endfunction

	task automatic apply_calendar_op(input date_req_t it, output date_rsp_t res);
		int unsigned rem;
		int unsigned left;
		logic [gda_pkg::STATUS_W-1:0] st;
		st = gda_pkg::STATUS_OK;
		if (it.op == gda_pkg::OP_SET) begin
			if (it.yr >= 1 && it.yr <= gda_pkg::MAX_YEAR &&
					it.mo >= gda_pkg::MONTH_JAN && it.mo <= gda_pkg::MONTH_DEC &&
					it.dy >= 1 && it.dy <= month_days(it.mo, it.yr)) begin
				cal_year = it.yr;
				cal_month = it.mo;
				cal_day = it.dy;
			end else begin
				st = gda_pkg::STATUS_INVALID;
			end
		end else begin
			rem = it.cnt;
			while (rem > 0) begin
				left = month_days(cal_month, cal_year) - cal_day;
				if (rem <= left) begin
					cal_day += rem;
					rem = 0;
				end else begin
					rem -= left + 1;
					cal_day = 1;
					if (cal_month >= gda_pkg::MONTH_DEC) begin
						if (cal_year >= gda_pkg::MAX_YEAR) begin
							cal_year = gda_pkg::MAX_YEAR;
							cal_month = gda_pkg::MONTH_DEC;
							cal_day = gda_pkg::DAY_LAST_DEC;
							st = gda_pkg::STATUS_OVERFLOW;
							rem = 0;
						end else begin
							cal_month = 1;
							cal_year += 1;
						end
					end else begin
						cal_month += 1;
					end
				end
			end
		end
		res.yr = gda_pkg::YEAR_W'(cal_year);
		res.mo = gda_pkg::MONTH_W'(cal_month);
		res.dy = gda_pkg::DAY_W'(cal_day);
		res.wd = gda_pkg::WD_W'(weekday_of(cal_year, cal_month, cal_day));
		res.st = st;
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic drive_item(input date_req_t it);
		if (!calm && $urandom_range(0, 99) < 33) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_row <= it;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
		end
	end

	always @(posedge clk) begin
		date_rsp_t res;
		date_rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				apply_calendar_op(req_row, res);
				date_q.push_back(req_row.typed ? req_row.want : res);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (date_q.size() == 0) begin
					report($sformatf("unexpected result %0d-%0d-%0d",
						rsp_ch.cur_year, rsp_ch.cur_month, rsp_ch.cur_day));
				end else begin
					want = date_q.pop_front();
					if (rsp_ch.cur_year !== want.yr)
						report($sformatf("year got %0d want %0d", rsp_ch.cur_year, want.yr));
					if (rsp_ch.cur_month !== want.mo)
						report($sformatf("month got %0d want %0d", rsp_ch.cur_month, want.mo));
					if (rsp_ch.cur_day !== want.dy)
						report($sformatf("day got %0d want %0d", rsp_ch.cur_day, want.dy));
					if (rsp_ch.weekday !== want.wd)
						report($sformatf("weekday got %0d want %0d", rsp_ch.weekday, want.wd));
					if (rsp_ch.status !== want.st)
						report($sformatf("status got %0d want %0d", rsp_ch.status, want.st));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		date_req_t it;
		int unsigned pick;
		arst_n <= 1'b0;
		calm <= 1'b0;
		req_ch.valid <= 1'b0;
		req_row <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) drive_item(dir_rows[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 30) calm <= 1'b1;
			if (n == 60) calm <= 1'b0;
			pick = $urandom_range(0, 99);
			it = '0;
			it.yr = gda_pkg::YEAR_W'($urandom_range(0, 16383));
			it.mo = gda_pkg::MONTH_W'($urandom_range(0, 15));
			it.dy = gda_pkg::DAY_W'($urandom_range(0, 31));
			it.cnt = gda_pkg::COUNT_FIELD_W'($urandom_range(0, 65535));
			if (pick < 40) begin
				it.op = gda_pkg::OP_SET;
				// mostly legal dates, some near the top year, the rest raw noise
				if (pick < 30) begin
					it.yr = gda_pkg::YEAR_W'((pick < 6) ? $urandom_range(9990, 9999)
						: $urandom_range(1, 9999));
					it.mo = gda_pkg::MONTH_W'($urandom_range(1, 12));
					it.dy = gda_pkg::DAY_W'($urandom_range(1, month_days(it.mo, it.yr)));
				end
			end else begin
				it.op = gda_pkg::OP_ADD;
				if (pick < 70) begin
					it.cnt = gda_pkg::COUNT_FIELD_W'($urandom_range(0, 40));
				end else if (pick < 90) begin
					it.cnt = gda_pkg::COUNT_FIELD_W'($urandom_range(0, 1000));
				end
			end
			drive_item(it);
		end
		req_ch.valid <= 1'b0;
		while (results_seen < items_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (date_q.size() != 0)
			report($sformatf("%0d results never arrived", date_q.size()));
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
